[rtl/idsm_pkg.sv]
// Shared types, event codes and timeout tables for the idle dim/sleep manager.
package idsm_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned SLEEP_W = 10;
  localparam int unsigned CHOICE_W = 3;
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned CFG_ADDR_W = 1;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVITY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STEP_DIM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP_SLEEP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TOGGLE     = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_BRIGHTNESS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIM_BRIGHTNESS    = 1'd1;

  localparam logic [LEVEL_W-1:0] ACTIVE_BRIGHTNESS_RST = 8'd200;
  localparam logic [LEVEL_W-1:0] DIM_BRIGHTNESS_RST    = 8'd24;

  localparam logic [CHOICE_W-1:0] DIM_CHOICE_RST   = 3'd2;
  localparam logic [CHOICE_W-1:0] SLEEP_CHOICE_RST = 3'd3;

  // tail entries repeat the last option
  localparam logic [DIM_W-1:0] DIM_TABLE [TABLE_DEPTH] = '{
    9'd15, 9'd30, 9'd60, 9'd120, 9'd300, 9'd300, 9'd300, 9'd300
  };
  localparam logic [SLEEP_W-1:0] SLEEP_TABLE [TABLE_DEPTH] = '{
    10'd0, 10'd60, 10'd120, 10'd300, 10'd600, 10'd900, 10'd900, 10'd900
  };

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [TIME_W-1:0]        now_ms;
    logic signed [STEP_W-1:0] step;
  } idsm_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   last_act;
    logic                act_valid;
    logic                dim_flag;
    logic                sleep_flag;
    logic                run_en;
    logic [CHOICE_W-1:0] dim_choice;
    logic [CHOICE_W-1:0] sleep_choice;
  } idsm_state_t;

  typedef struct packed {
    logic                deep_sleep_request;
    logic [TIME_W-1:0]   idle_ms;
    logic [SLEEP_W-1:0]  sleep_after_s;
    logic [DIM_W-1:0]    dim_after_s;
    logic                enabled;
    logic                sleeping;
    logic                dimmed;
    logic [LEVEL_W-1:0]  brightness_level;
    logic                brightness_write;
    logic                changed;
  } idsm_result_t;

endpackage

[rtl/idsm_wrap.sv]
// Steps a table choice by a signed offset, wrapping round the option count.
module idsm_wrap import idsm_pkg::*; #(
  parameter int unsigned COUNT = 5
) (
  input  logic [CHOICE_W-1:0]       cur,
  input  logic signed [STEP_W-1:0]  delta,
  output logic [CHOICE_W-1:0]       nxt
);

  localparam int unsigned SUM_W = STEP_W + 1;
  localparam int unsigned LUT_DEPTH = 1 << SUM_W;

  logic [CHOICE_W-1:0] wrap_lut [LUT_DEPTH];
  logic [SUM_W-1:0]    sum_off;

  // index is cur + delta + 8, so the lut covers offsets -8 to +23
  for (genvar g = 0; g < LUT_DEPTH; g++) begin : g_lut
    localparam int unsigned WRAPPED = (g + 8 * COUNT - 8) % COUNT;
    assign wrap_lut[g] = CHOICE_W'(WRAPPED);
  end

  assign sum_off = SUM_W'(cur) + {delta[STEP_W-1], delta} + SUM_W'(8);
  assign nxt     = wrap_lut[sum_off];

endmodule

[rtl/idsm_eval.sv]
// Next-state and result logic for one event of the idle manager.
module idsm_eval import idsm_pkg::*; #(
  parameter int unsigned DIM_OPTION_COUNT   = 5,
  parameter int unsigned SLEEP_OPTION_COUNT = 6,
  parameter int unsigned MS_PER_SECOND      = 1000
) (
  input  idsm_item_t          item,
  input  idsm_state_t         cur,
  input  logic [LEVEL_W-1:0]  active_level,
  input  logic [LEVEL_W-1:0]  dim_level,
  output idsm_state_t         nxt,
  output idsm_result_t        res
);

  localparam int unsigned THR_W = SLEEP_W + $clog2(MS_PER_SECOND + 1);
  localparam int unsigned CMP_W = (THR_W > TIME_W) ? THR_W : TIME_W;

  logic [CMP_W-1:0]    dim_thr   [TABLE_DEPTH];
  logic [CMP_W-1:0]    sleep_thr [TABLE_DEPTH];
  logic [TIME_W-1:0]   tick_diff;
  logic [DIM_W-1:0]    dim_s_cur;
  logic [SLEEP_W-1:0]  sleep_s_cur;
  logic                want_sleep;
  logic                want_dim;
  logic [CHOICE_W-1:0] dim_stepped;
  logic [CHOICE_W-1:0] sleep_stepped;
  logic signed [STEP_W-1:0] sleep_delta;
  logic                push_sleep;

  // timeouts in ms, fixed at elaboration
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_thr
    localparam longint unsigned DIM_T   = longint'(DIM_TABLE[g]) * MS_PER_SECOND;
    localparam longint unsigned SLEEP_T = longint'(SLEEP_TABLE[g]) * MS_PER_SECOND;
    assign dim_thr[g]   = CMP_W'(DIM_T);
    assign sleep_thr[g] = CMP_W'(SLEEP_T);
  end

  assign dim_s_cur   = DIM_TABLE[cur.dim_choice];
  assign sleep_s_cur = SLEEP_TABLE[cur.sleep_choice];

  // first tick with nothing recorded counts from itself
  assign tick_diff  = item.now_ms - (cur.act_valid ? cur.last_act : item.now_ms);
  assign want_sleep = (sleep_s_cur != '0) &&
                      (CMP_W'(tick_diff) >= sleep_thr[cur.sleep_choice]);
  assign want_dim   = !want_sleep && (CMP_W'(tick_diff) >= dim_thr[cur.dim_choice]);

  assign sleep_delta = (item.mode == MODE_STEP_SLEEP) ? item.step : STEP_W'(1);
  assign push_sleep  = (sleep_s_cur != '0) &&
                       (SLEEP_W'(DIM_TABLE[dim_stepped]) >= sleep_s_cur);

  idsm_wrap #(.COUNT(DIM_OPTION_COUNT)) u_dim_wrap (
    .cur   (cur.dim_choice),
    .delta (item.step),
    .nxt   (dim_stepped)
  );

  idsm_wrap #(.COUNT(SLEEP_OPTION_COUNT)) u_sleep_wrap (
    .cur   (cur.sleep_choice),
    .delta (sleep_delta),
    .nxt   (sleep_stepped)
  );

  always_comb begin
    nxt = cur;
    res = '0;
    case (item.mode)
      MODE_TICK: begin
        if (!cur.act_valid) begin
          nxt.last_act  = item.now_ms;
          nxt.act_valid = 1'b1;
        end
        if (!cur.run_en) begin
          if (cur.dim_flag || cur.sleep_flag) begin
            nxt.dim_flag         = 1'b0;
            nxt.sleep_flag       = 1'b0;
            res.brightness_write = 1'b1;
            res.brightness_level = active_level;
            res.changed          = 1'b1;
          end
        end else if ((want_sleep != cur.sleep_flag) || (want_dim != cur.dim_flag)) begin
          nxt.sleep_flag       = want_sleep;
          nxt.dim_flag         = want_dim;
          res.brightness_write = 1'b1;
          res.brightness_level = want_sleep ? '0 : (want_dim ? dim_level : active_level);
          res.changed          = 1'b1;
        end
      end
      MODE_ACTIVITY: begin
        nxt.last_act  = item.now_ms;
        nxt.act_valid = 1'b1;
        if (cur.dim_flag || cur.sleep_flag) begin
          nxt.dim_flag         = 1'b0;
          nxt.sleep_flag       = 1'b0;
          res.brightness_write = 1'b1;
          res.brightness_level = active_level;
        end
      end
      MODE_STEP_DIM: begin
        nxt.dim_choice = dim_stepped;
        if (push_sleep) begin
          nxt.sleep_choice = sleep_stepped;
        end
      end
      MODE_STEP_SLEEP: begin
        nxt.sleep_choice = sleep_stepped;
      end
      MODE_TOGGLE: begin
        nxt.run_en = !cur.run_en;
        if (cur.run_en) begin
          nxt.dim_flag         = 1'b0;
          nxt.sleep_flag       = 1'b0;
          res.brightness_write = 1'b1;
          res.brightness_level = active_level;
        end
      end
      default: begin
      end
    endcase
    res.dimmed             = nxt.dim_flag;
    res.sleeping           = nxt.sleep_flag;
    res.enabled            = nxt.run_en;
    res.dim_after_s        = DIM_TABLE[nxt.dim_choice];
    res.sleep_after_s      = SLEEP_TABLE[nxt.sleep_choice];
    res.idle_ms            = nxt.act_valid ? (item.now_ms - nxt.last_act) : '0;
    res.deep_sleep_request = nxt.run_en && nxt.sleep_flag;
  end

endmodule

[rtl/idle_dim_sleep_manager_core.sv]
// Top level of the backlight idle manager: request registers, state and result register.
//
// Usage:
//   in_*  carries one event per request: in_tuser holds the event kind, in_tdata
//         the time in ms and a signed table step. Every request yields exactly
//         one result on out_*, in order.
//   out_* carries the brightness write, the dim/sleep/enable flags, both
//         timeouts in seconds, the idle time in ms and the deep-sleep request.
//   cfg_* writes the active (index 0) and dim (index 1) backlight levels;
//         write only while no request is in flight.
// Flow: an accepted request is held in the request register, evaluated
//   combinationally, and its result is registered in the result register.
// Throughput: one request per cycle while out_tready is high, set by the single
//   evaluation stage between the request register and the result register.
// Stall: while out_tready is low the result register holds; one more request
//   waits in the request register, after which in_tready drops.
// Reset: flags clear, management enabled, no activity recorded, timeouts at
//   60 s dim and 300 s sleep, levels at 200 and 24.
module idle_dim_sleep_manager_core import idsm_pkg::*; #(
  parameter int unsigned DIM_OPTION_COUNT   = 5,
  parameter int unsigned SLEEP_OPTION_COUNT = 6,
  parameter int unsigned MS_PER_SECOND      = 1000
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // now_ms[31:0], step[35:32], zero pad
  input  logic [MODE_W-1:0]       in_tuser,   // mode[2:0]
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // changed[0], brightness_write[1], brightness_level[9:2], dimmed[10],
  // sleeping[11], enabled[12], dim_after_s[21:13], sleep_after_s[31:22],
  // idle_ms[63:32], deep_sleep_request[64], zero pad
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [LEVEL_W-1:0]      cfg_wdata
);

  localparam logic [CHOICE_W-1:0] DIM_RST =
    (DIM_CHOICE_RST >= DIM_OPTION_COUNT) ? CHOICE_W'(DIM_OPTION_COUNT - 1) : DIM_CHOICE_RST;
  localparam logic [CHOICE_W-1:0] SLEEP_RST =
    (SLEEP_CHOICE_RST >= SLEEP_OPTION_COUNT) ?
      CHOICE_W'(SLEEP_OPTION_COUNT - 1) : SLEEP_CHOICE_RST;
  localparam int unsigned RES_W = $bits(idsm_result_t);

  idsm_item_t         item_r;
  logic               item_valid_r;
  logic               item_valid_nxt;
  idsm_state_t        state_r;
  idsm_state_t        state_nxt;
  idsm_result_t       res_r;
  idsm_result_t       res_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [LEVEL_W-1:0] active_level_r;
  logic [LEVEL_W-1:0] dim_level_r;
  logic               in_fire;
  logic               advance;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, res_r};

  idsm_eval #(
    .DIM_OPTION_COUNT   (DIM_OPTION_COUNT),
    .SLEEP_OPTION_COUNT (SLEEP_OPTION_COUNT),
    .MS_PER_SECOND      (MS_PER_SECOND)
  ) u_eval (
    .item         (item_r),
    .cur          (state_r),
    .active_level (active_level_r),
    .dim_level    (dim_level_r),
    .nxt          (state_nxt),
    .res          (res_nxt)
  );

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_fire) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
      active_level_r <= ACTIVE_BRIGHTNESS_RST;
      dim_level_r    <= DIM_BRIGHTNESS_RST;
      state_r        <= '{
        last_act:     '0,
        act_valid:    1'b0,
        dim_flag:     1'b0,
        sleep_flag:   1'b0,
        run_en:       1'b1,
        dim_choice:   DIM_RST,
        sleep_choice: SLEEP_RST
      };
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_we && (cfg_addr == REG_ACTIVE_BRIGHTNESS)) begin
        active_level_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == REG_DIM_BRIGHTNESS)) begin
        dim_level_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.mode   <= in_tuser;
      item_r.now_ms <= in_tdata[TIME_W-1:0];
      item_r.step   <= in_tdata[TIME_W +: STEP_W];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule
